>>> design/hslrgb_pkg.sv
package hslrgb_pkg;

    // fixed-point format of the color fractions
    localparam int FRAC_BITS = 12;
    localparam int ONE_I     = 1 << FRAC_BITS;
    localparam int IN_W      = 13;
    localparam int VAL_W     = FRAC_BITS + 1;
    // hue positions are kept as six times the hue, so sixths of a turn are exact
    localparam int T6_W      = FRAC_BITS + 3;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int BYTE_W    = 8;

    localparam logic [VAL_W-1:0]  ONE      = VAL_W'(ONE_I);
    localparam logic [VAL_W-1:0]  HALF     = VAL_W'(ONE_I >> 1);
    localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};

    // input pixel
    typedef struct packed {
        logic [IN_W-1:0] hue;
        logic [IN_W-1:0] saturation;
        logic [IN_W-1:0] lightness;
    } t_hsl;

    // output pixel
    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } t_rgb;

    // stage loads of the per-channel tail
    typedef struct packed {
        logic load_prod;
        logic load_out;
    } t_chan_en;

endpackage

>>> design/hslrgb_channel.sv
module hslrgb_channel
    import hslrgb_pkg::*;
(
    input  logic              i_clk,
    input  t_chan_en          i_en,
    input  logic [T6_W-1:0]   i_t6,
    input  logic [VAL_W-1:0]  i_p,
    input  logic [VAL_W-1:0]  i_q,
    output logic [BYTE_W-1:0] o_byte
);

    typedef enum logic [1:0] {
        SEG_RISE = 2'd0,
        SEG_HIGH = 2'd1,
        SEG_FALL = 2'd2,
        SEG_LOW  = 2'd3
    } t_seg;

    logic [VAL_W-1:0]  w_diff;
    logic [T6_W-1:0]   w_fall_pos;
    logic [VAL_W-1:0]  w_factor;
    t_seg              w_seg;

    t_seg              r_seg;
    logic [PROD_W-1:0] r_prod;
    logic [VAL_W-1:0]  r_p;
    logic [VAL_W-1:0]  r_q;
    logic [BYTE_W-1:0] r_byte;

    logic [VAL_W:0]    w_ramp_sum;
    logic [VAL_W-1:0]  w_value;
    logic [VAL_W+7:0]  w_scaled;
    logic [VAL_W+7-FRAC_BITS:0] w_byte_full;

    // pick the ramp segment and the slope factor
    always_comb begin
        w_diff     = i_q - i_p;
        w_fall_pos = T6_W'(4 * ONE_I) - i_t6;
        w_factor   = '0;
        if (i_t6 < T6_W'(ONE_I)) begin
            w_seg    = SEG_RISE;
            w_factor = VAL_W'(i_t6);
        end else if (i_t6 < T6_W'(3 * ONE_I)) begin
            w_seg = SEG_HIGH;
        end else if (i_t6 < T6_W'(4 * ONE_I)) begin
            w_seg    = SEG_FALL;
            w_factor = VAL_W'(w_fall_pos);
        end else begin
            w_seg = SEG_LOW;
        end
    end

    // slope product stage
    always_ff @(posedge i_clk) begin
        if (i_en.load_prod) begin
            r_seg  <= w_seg;
            r_prod <= PROD_W'(w_diff) * PROD_W'(w_factor);
            r_p    <= i_p;
            r_q    <= i_q;
        end
    end

    // ramp value, then scale by 255 as a shift and subtract
    always_comb begin
        w_ramp_sum = VAL_W'(r_p) + r_prod[FRAC_BITS +: VAL_W];
        case (r_seg)
            SEG_RISE: w_value = VAL_W'(w_ramp_sum);
            SEG_FALL: w_value = VAL_W'(w_ramp_sum);
            SEG_HIGH: w_value = r_q;
            SEG_LOW:  w_value = r_p;
            default:  w_value = r_p;
        endcase
        w_scaled    = {w_value, 8'b0} - (VAL_W+8)'(w_value);
        w_byte_full = w_scaled[VAL_W+7:FRAC_BITS];
    end

    // output byte stage, saturated
    always_ff @(posedge i_clk) begin
        if (i_en.load_out) begin
            if (w_byte_full > (VAL_W+8-FRAC_BITS)'(BYTE_MAX)) begin
                r_byte <= BYTE_MAX;
            end else begin
                r_byte <= BYTE_W'(w_byte_full);
            end
        end
    end

    assign o_byte = r_byte;

endmodule

>>> design/hsl_to_rgb_converter_core.sv
// hsl to rgb color converter, one pixel per clock while the receiver is ready
//
// input channel: i_in_valid / o_in_ready with i_in_data carrying hue,
// saturation and lightness as unsigned Q12 fractions (4096 = 1.0, hue
// wraps at one full turn). output channel: o_out_valid / i_out_ready with
// o_out_data carrying 8-bit red, green and blue.
//
// five register stages: clamp, lightness*saturation product, q/p, ramp
// slope product, scale to byte. with the receiver ready one pixel is
// taken every clock.
//
// each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so empty stages fill while the receiver stalls;
// o_in_ready drops only once all five stages hold a pixel.
// synchronous active-low reset empties the pipeline; the data registers are not reset.
module hsl_to_rgb_converter_core
    import hslrgb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_hsl i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rgb o_out_data
);

    logic [5:1] r_valid;
    logic [5:1] w_en;
    logic       w_in_xfer;

    logic [FRAC_BITS-1:0] r1_hue;
    logic [VAL_W-1:0]     r1_sat;
    logic [VAL_W-1:0]     r1_light;

    logic [T6_W-1:0]      w_h6;
    logic [T6_W:0]        w_sum_r;
    logic [T6_W:0]        w_sum_b;
    logic [T6_W-1:0]      w_t6_r;
    logic [T6_W-1:0]      w_t6_b;

    logic [PROD_W-1:0]    r2_ls;
    logic [VAL_W-1:0]     r2_sat;
    logic [VAL_W-1:0]     r2_light;
    logic [T6_W-1:0]      r2_t6_r;
    logic [T6_W-1:0]      r2_t6_g;
    logic [T6_W-1:0]      r2_t6_b;

    logic [VAL_W-1:0]     w_ls_hi;
    logic [VAL_W:0]       w_q_full;
    logic [VAL_W-1:0]     w_q;
    logic signed [VAL_W+1:0] w_ps;
    logic [VAL_W-1:0]     w_p;

    logic [VAL_W-1:0]     r3_p;
    logic [VAL_W-1:0]     r3_q;
    logic [T6_W-1:0]      r3_t6_r;
    logic [T6_W-1:0]      r3_t6_g;
    logic [T6_W-1:0]      r3_t6_b;

    t_chan_en             w_chan_en;
    logic [BYTE_W-1:0]    w_red;
    logic [BYTE_W-1:0]    w_green;
    logic [BYTE_W-1:0]    w_blue;

    // stage loads: a stage moves when empty or when the next one moves
    always_comb begin
        w_en[5] = !r_valid[5] || i_out_ready;
        w_en[4] = !r_valid[4] || w_en[5];
        w_en[3] = !r_valid[3] || w_en[4];
        w_en[2] = !r_valid[2] || w_en[3];
        w_en[1] = !r_valid[1] || w_en[2];
    end

    assign o_in_ready = w_en[1];
    assign w_in_xfer  = i_in_valid && w_en[1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[1]) r_valid[1] <= i_in_valid;
            if (w_en[2]) r_valid[2] <= r_valid[1];
            if (w_en[3]) r_valid[3] <= r_valid[2];
            if (w_en[4]) r_valid[4] <= r_valid[3];
            if (w_en[5]) r_valid[5] <= r_valid[4];
        end
    end

    // stage 1: hue wrap and clamp of saturation and lightness
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_hue   <= i_in_data.hue[FRAC_BITS-1:0];
            r1_sat   <= (i_in_data.saturation > IN_W'(ONE_I)) ?
                        ONE : VAL_W'(i_in_data.saturation);
            r1_light <= (i_in_data.lightness > IN_W'(ONE_I)) ?
                        ONE : VAL_W'(i_in_data.lightness);
        end
    end

    // six times hue, offset by a third of a turn each way and wrapped
    always_comb begin
        w_h6    = T6_W'({r1_hue, 2'b00}) + T6_W'({r1_hue, 1'b0});
        w_sum_r = (T6_W+1)'(w_h6) + (T6_W+1)'(2 * ONE_I);
        w_sum_b = (T6_W+1)'(w_h6) + (T6_W+1)'(4 * ONE_I);
        w_t6_r  = (w_sum_r >= (T6_W+1)'(6 * ONE_I)) ?
                  T6_W'(w_sum_r - (T6_W+1)'(6 * ONE_I)) : T6_W'(w_sum_r);
        w_t6_b  = (w_sum_b >= (T6_W+1)'(6 * ONE_I)) ?
                  T6_W'(w_sum_b - (T6_W+1)'(6 * ONE_I)) : T6_W'(w_sum_b);
    end

    // stage 2: lightness times saturation
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_ls    <= PROD_W'(r1_light) * PROD_W'(r1_sat);
            r2_sat   <= r1_sat;
            r2_light <= r1_light;
            r2_t6_r  <= w_t6_r;
            r2_t6_g  <= w_h6;
            r2_t6_b  <= w_t6_b;
        end
    end

    // q and p, with p clamped into [0, q]
    always_comb begin
        w_ls_hi = r2_ls[FRAC_BITS +: VAL_W];
        if (r2_light < HALF) begin
            w_q_full = (VAL_W+1)'(r2_light) + (VAL_W+1)'(w_ls_hi);
        end else begin
            w_q_full = (VAL_W+1)'(r2_light) + (VAL_W+1)'(r2_sat)
                       - (VAL_W+1)'(w_ls_hi);
        end
        w_q  = VAL_W'(w_q_full);
        w_ps = $signed({1'b0, r2_light, 1'b0}) - $signed({2'b00, w_q});
        if (w_ps[VAL_W+1]) begin
            w_p = '0;
        end else if (w_ps[VAL_W:0] > {1'b0, w_q}) begin
            w_p = w_q;
        end else begin
            w_p = w_ps[VAL_W-1:0];
        end
    end

    // stage 3: q, p and hue positions
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_p    <= w_p;
            r3_q    <= w_q;
            r3_t6_r <= r2_t6_r;
            r3_t6_g <= r2_t6_g;
            r3_t6_b <= r2_t6_b;
        end
    end

    // stages 4 and 5 per channel
    assign w_chan_en = '{load_prod: w_en[4], load_out: w_en[5]};

    hslrgb_channel u_red (
        .i_clk  (i_clk),
        .i_en   (w_chan_en),
        .i_t6   (r3_t6_r),
        .i_p    (r3_p),
        .i_q    (r3_q),
        .o_byte (w_red)
    );

    hslrgb_channel u_green (
        .i_clk  (i_clk),
        .i_en   (w_chan_en),
        .i_t6   (r3_t6_g),
        .i_p    (r3_p),
        .i_q    (r3_q),
        .o_byte (w_green)
    );

    hslrgb_channel u_blue (
        .i_clk  (i_clk),
        .i_en   (w_chan_en),
        .i_t6   (r3_t6_b),
        .i_p    (r3_p),
        .i_q    (r3_q),
        .o_byte (w_blue)
    );

    assign o_out_valid = r_valid[5];
    assign o_out_data  = '{red: w_red, green: w_green, blue: w_blue};

    // an empty first stage always takes a transfer
    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[1] |-> o_in_ready)
        else $error("input not ready with first stage empty");

    // a transfer in lands in the first stage
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_valid[1])
        else $error("accepted pixel lost at first stage");

    // a ready receiver lets the whole pipeline flow
    a_ready_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("pipeline stalled with receiver ready");

    // a stalled full tail keeps the pixel in stage 4
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[5] && r_valid[4] && !i_out_ready) |=> r_valid[4])
        else $error("stage 4 pixel dropped during stall");

endmodule

>>> tb/testbench.sv
module testbench;
    import hslrgb_pkg::*;

    // scoreboard: predicts each pixel's color and checks results in order
    class rgb_scoreboard;
        t_rgb expected_rgb[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        // piecewise hue ramp, position given as six times the hue
        function automatic longint unsigned ramp_level(longint unsigned p,
                                                       longint unsigned q,
                                                       longint unsigned t6);
            longint unsigned d;
            d = q - p;
            if (t6 < ONE_I)
                return p + ((d * t6) >> FRAC_BITS);
            if (t6 < 3 * ONE_I)
                return q;
            if (t6 < 4 * ONE_I)
                return p + ((d * (4 * ONE_I - t6)) >> FRAC_BITS);
            return p;
        endfunction

        // scale a channel fraction to a byte, saturated
        function automatic logic [BYTE_W-1:0] scale_byte(longint unsigned v);
            longint unsigned b;
            b = (v * 255) >> FRAC_BITS;
            if (b > 255)
                b = 255;
            return b[BYTE_W-1:0];
        endfunction

        function automatic t_rgb predict_rgb(t_hsl px);
            longint unsigned h, s, l, q, p, h6, turn;
            longint unsigned r, g, b;
            longint          p_signed;
            t_rgb            c;
            h = px.hue % ONE_I;
            s = px.saturation;
            l = px.lightness;
            if (s > ONE_I)
                s = ONE_I;
            if (l > ONE_I)
                l = ONE_I;
            if (s == 0) begin
                r = l;
                g = l;
                b = l;
            end else begin
                if (l < (ONE_I >> 1))
                    q = (l * (ONE_I + s)) >> FRAC_BITS;
                else
                    q = l + s - ((l * s) >> FRAC_BITS);
                // p can dip below zero or above q through truncation
                p_signed = longint'(2 * l) - longint'(q);
                if (p_signed < 0)
                    p_signed = 0;
                p = longint'(p_signed);
                if (p > q)
                    p = q;
                turn = 6 * ONE_I;
                h6   = 6 * h;
                r = ramp_level(p, q, (h6 + 2 * ONE_I) % turn);
                g = ramp_level(p, q, h6);
                b = ramp_level(p, q, (h6 + 4 * ONE_I) % turn);
            end
            c.red   = scale_byte(r);
            c.green = scale_byte(g);
            c.blue  = scale_byte(b);
            return c;
        endfunction

        function void note_pixel(t_hsl px);
            expected_rgb.push_back(predict_rgb(px));
        endfunction

        function void check_pixel(t_rgb got);
            t_rgb want;
            if (expected_rgb.size() == 0) begin
                $error("unexpected result transfer: %h", got);
                errors++;
                return;
            end
            want = expected_rgb.pop_front();
            if (got.red !== want.red) begin
                $error("red mismatch: expected %0d, actual %0d", want.red, got.red);
                errors++;
            end
            if (got.green !== want.green) begin
                $error("green mismatch: expected %0d, actual %0d", want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue) begin
                $error("blue mismatch: expected %0d, actual %0d", want.blue, got.blue);
                errors++;
            end
        endfunction
    endclass

    localparam int RANDOM_PIXELS = 1400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_hsl in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_rgb out_data;

    rgb_scoreboard color_check = new();

    hsl_to_rgb_converter_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // clock
    initial begin
        forever #10 clk = ~clk;
    end

    // run limit
    initial begin
        #10000000;
        $display("testbench: errors");
        $finish;
    end

    // idle length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic t_hsl make_hsl(int h, int s, int l);
        t_hsl px;
        px.hue        = h[IN_W-1:0];
        px.saturation = s[IN_W-1:0];
        px.lightness  = l[IN_W-1:0];
        return px;
    endfunction

    // mostly in-range colors, some grey, some full-width noise
    function automatic t_hsl random_pixel();
        t_hsl px;
        int   mode;
        mode = $urandom_range(0, 9);
        if (mode < 7) begin
            px.hue        = IN_W'($urandom_range(0, ONE_I));
            px.saturation = ($urandom_range(0, 9) == 0) ?
                            '0 : IN_W'($urandom_range(0, ONE_I));
            px.lightness  = IN_W'($urandom_range(0, ONE_I));
        end else begin
            px.hue        = IN_W'($urandom);
            px.saturation = IN_W'($urandom);
            px.lightness  = IN_W'($urandom);
        end
        return px;
    endfunction

    // hold valid and payload until the transfer, then idle for the given gap
    task automatic send_pixel(input t_hsl px, input int gap);
        in_valid <= 1'b1;
        in_data  <= px;
        do @(posedge clk); while (!in_ready);
        color_check.note_pixel(px);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_directed();
        // extremes and grey
        send_pixel(make_hsl(0, 0, 0), pick_gap());
        send_pixel(make_hsl(0, 0, ONE_I), pick_gap());
        send_pixel(make_hsl(1234, 0, 2048), pick_gap());
        send_pixel(make_hsl(0, ONE_I, 2048), pick_gap());
        send_pixel(make_hsl(4095, ONE_I, 2047), pick_gap());
        // hue at and past one full turn
        send_pixel(make_hsl(ONE_I, ONE_I, 2048), pick_gap());
        send_pixel(make_hsl(8191, 3000, 1500), pick_gap());
        // saturation and lightness above one
        send_pixel(make_hsl(700, 8191, 1000), pick_gap());
        send_pixel(make_hsl(1500, 2000, 8191), pick_gap());
        send_pixel(make_hsl(8191, 8191, 8191), pick_gap());
        // tiny lightness drives p toward zero, full lightness with tiny saturation
        send_pixel(make_hsl(300, ONE_I, 1), pick_gap());
        send_pixel(make_hsl(2500, 1, ONE_I), pick_gap());
        send_pixel(make_hsl(2500, 1, 4095), pick_gap());
        // hue around the sixth-of-a-turn boundaries
        send_pixel(make_hsl(682, ONE_I, 2048), pick_gap());
        send_pixel(make_hsl(683, ONE_I, 2048), pick_gap());
        send_pixel(make_hsl(1365, 3000, 2047), pick_gap());
        send_pixel(make_hsl(1366, 3000, 2048), pick_gap());
        send_pixel(make_hsl(2048, 2000, 3000), pick_gap());
        send_pixel(make_hsl(2730, 4000, 1000), pick_gap());
        send_pixel(make_hsl(2731, 4000, 1000), pick_gap());
        send_pixel(make_hsl(3413, 1000, 3500), pick_gap());
        send_pixel(make_hsl(3414, 1000, 3500), 0);
        // lightness at the half boundary
        send_pixel(make_hsl(100, 2500, 2047), 0);
        send_pixel(make_hsl(100, 2500, 2048), pick_gap());
    endtask

    // sender: reset, directed pixels, random pixels, then drain
    initial begin
        int gap;
        int drain_cycles;
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            // back-to-back stretches every so often
            gap = (((i / 128) % 4) == 3) ? 0 : pick_gap();
            send_pixel(random_pixel(), gap);
        end
        in_valid <= 1'b0;
        while (color_check.expected_rgb.size() != 0)
            @(posedge clk);
        drain_cycles = 20;
        repeat (drain_cycles) @(posedge clk);
        if (color_check.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // receiver: random stalls, one long hold-off, result checking
    initial begin
        int stall_left;
        int cycle_no;
        int results_seen;
        bit long_hold_done;
        stall_left     = 0;
        cycle_no       = 0;
        results_seen   = 0;
        long_hold_done = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            @(posedge clk);
            cycle_no++;
            if (out_valid && out_ready) begin
                color_check.check_pixel(out_data);
                results_seen++;
            end
            // long hold-off so the pipeline fills and stalls its input
            if (!long_hold_done && results_seen >= 300) begin
                long_hold_done = 1'b1;
                stall_left     = 100;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (((cycle_no / 200) % 4) == 1) begin
                out_ready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    out_ready <= 1'b0;
                end else begin
                    out_ready <= 1'b1;
                end
            end
        end
    end

endmodule
